### design/mcew_pkg.sv
// Shared widths, codes and types of the cotangent edge weight block.
// Used by mcew_cot and mesh_cotangent_edge_weights; no dependencies.
package mcew_pkg;

   localparam int IDX_W   = 20;
   localparam int COORD_W = 32;
   localparam int DIFF_W  = 33;
   localparam int PROD_W  = 66;
   localparam int DOT_W   = 68;
   localparam int MAG_W   = 68;
   localparam int HALF_W  = 34;
   localparam int SQ_W    = 136;
   localparam int NSQ_W   = 138;
   localparam int DSQ_W   = 166;
   localparam int TERM_W  = 171;
   localparam int CAND_W  = 204;
   localparam int Q_W     = 32;
   localparam int FACE_W  = 22;
   localparam int CSR_IDX_W = 2;

   localparam logic [FACE_W-1:0] MAX_FACES = 22'd2097152;

   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FACE_COUNT  = 2'd1;

   localparam logic [Q_W-1:0] WEIGHT_ONE = 32'h0001_0000;
   localparam logic [Q_W-1:0] POS_SAT    = 32'h7FFF_FFFF;
   localparam logic [Q_W-1:0] NEG_SAT    = 32'h8000_0000;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } point_type;

   typedef struct packed {
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic             last_face;
      logic             last_mesh;
      logic             graph;
   } meta_type;

endpackage

### design/mesh_cotangent_edge_weights.sv
// Top level of the cotangent edge weight block: request capture, face counter, registers.
// Depends on mcew_pkg and mcew_cot.
//
//   channel  ports                       handshake
//   request  req_start, busy, req_*      taken when req_start is high and busy is low
//   result   rsp_valid, rsp_*            one-cycle strobe, no back-pressure
//   config   csr_valid, csr_ready, csr_* written when csr_valid and csr_ready are high
//
// A request is taken only once the previous one's third corner issues; its corners enter
// the weight pipeline one per cycle, so the issue sequencer sets the rate.
// The three results of a request appear on consecutive cycles, once the corners have
// passed through the pipeline stages of the weight unit.
// Reset clears face counter and valids, sets both CSRs to 1; results cannot be stalled.
module mesh_cotangent_edge_weights (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_start,
   output logic                                busy,
   input  logic [mcew_pkg::IDX_W-1:0]          req_vertex_a_index,
   input  logic [mcew_pkg::IDX_W-1:0]          req_vertex_b_index,
   input  logic [mcew_pkg::IDX_W-1:0]          req_vertex_c_index,
   input  logic signed [31:0]                  req_vertex_a_x,
   input  logic signed [31:0]                  req_vertex_a_y,
   input  logic signed [31:0]                  req_vertex_a_z,
   input  logic signed [31:0]                  req_vertex_b_x,
   input  logic signed [31:0]                  req_vertex_b_y,
   input  logic signed [31:0]                  req_vertex_b_z,
   input  logic signed [31:0]                  req_vertex_c_x,
   input  logic signed [31:0]                  req_vertex_c_y,
   input  logic signed [31:0]                  req_vertex_c_z,
   output logic                                rsp_valid,
   output logic [mcew_pkg::IDX_W-1:0]          rsp_row_index,
   output logic [mcew_pkg::IDX_W-1:0]          rsp_column_index,
   output logic signed [31:0]                  rsp_edge_weight,
   output logic                                rsp_last_of_face,
   output logic                                rsp_last_of_mesh,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mcew_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mcew_pkg::FACE_W-1:0]         csr_data
);
   import mcew_pkg::*;

   typedef enum logic [1:0] {CORNER_AB, CORNER_BC, CORNER_CA} corner_type;

   logic                 accept;
   logic                 weight_mode_ff;
   logic [FACE_W-1:0]    face_count_ff;
   logic [FACE_W-1:0]    faces_seen_ff;
   logic [FACE_W-1:0]    limit;
   logic                 last_mesh_in;
   logic [IDX_W-1:0]     idx_ff [3];
   point_type            pt_ff [3];
   logic                 last_mesh_ff;
   logic                 graph_ff;
   logic                 issue_ff;
   corner_type           corner_ff;
   meta_type             issue_meta;
   point_type            pi_sel, pm_sel, pj_sel;
   meta_type             cot_meta;
   logic                 cot_valid;
   logic signed [31:0]   cot_weight;

   assign busy      = issue_ff && (corner_ff != CORNER_CA);
   assign accept    = req_start && !busy;
   assign csr_ready = 1'b1;

   always_comb begin
      if (face_count_ff == '0) begin
         limit = FACE_W'(1);
      end else if (face_count_ff > MAX_FACES) begin
         limit = MAX_FACES;
      end else begin
         limit = face_count_ff;
      end
      last_mesh_in = ({1'b0, faces_seen_ff} + (FACE_W + 1)'(1)) >= {1'b0, limit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_mode_ff <= 1'b1;
         face_count_ff  <= FACE_W'(1);
         faces_seen_ff  <= '0;
         issue_ff       <= 1'b0;
         corner_ff      <= CORNER_AB;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WEIGHT_MODE: weight_mode_ff <= csr_data[0];
               CSR_FACE_COUNT:  face_count_ff  <= csr_data;
               default: ;
            endcase
         end
         if (accept) begin
            faces_seen_ff <= last_mesh_in ? '0 : faces_seen_ff + FACE_W'(1);
            issue_ff      <= 1'b1;
            corner_ff     <= CORNER_AB;
         end else if (issue_ff) begin
            case (corner_ff)
               CORNER_AB: corner_ff <= CORNER_BC;
               CORNER_BC: corner_ff <= CORNER_CA;
               default:   issue_ff  <= 1'b0;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         idx_ff[0]    <= req_vertex_a_index;
         idx_ff[1]    <= req_vertex_b_index;
         idx_ff[2]    <= req_vertex_c_index;
         pt_ff[0]     <= '{req_vertex_a_x, req_vertex_a_y, req_vertex_a_z};
         pt_ff[1]     <= '{req_vertex_b_x, req_vertex_b_y, req_vertex_b_z};
         pt_ff[2]     <= '{req_vertex_c_x, req_vertex_c_y, req_vertex_c_z};
         last_mesh_ff <= last_mesh_in;
         graph_ff     <= !weight_mode_ff;
      end
   end

   always_comb begin
      issue_meta.graph     = graph_ff;
      issue_meta.last_face = 1'b0;
      issue_meta.last_mesh = 1'b0;
      case (corner_ff)
         CORNER_AB: begin
            issue_meta.row = idx_ff[0];
            issue_meta.col = idx_ff[1];
            pi_sel = pt_ff[0];
            pj_sel = pt_ff[1];
            pm_sel = pt_ff[2];
         end
         CORNER_BC: begin
            issue_meta.row = idx_ff[1];
            issue_meta.col = idx_ff[2];
            pi_sel = pt_ff[1];
            pj_sel = pt_ff[2];
            pm_sel = pt_ff[0];
         end
         default: begin
            issue_meta.row       = idx_ff[2];
            issue_meta.col       = idx_ff[0];
            issue_meta.last_face = 1'b1;
            issue_meta.last_mesh = last_mesh_ff;
            pi_sel = pt_ff[2];
            pj_sel = pt_ff[0];
            pm_sel = pt_ff[1];
         end
      endcase
   end

   mcew_cot u_cot (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (issue_ff),
      .in_meta    (issue_meta),
      .in_pi      (pi_sel),
      .in_pm      (pm_sel),
      .in_pj      (pj_sel),
      .out_valid  (cot_valid),
      .out_meta   (cot_meta),
      .out_weight (cot_weight)
   );

   assign rsp_valid        = cot_valid;
   assign rsp_row_index    = cot_meta.row;
   assign rsp_column_index = cot_meta.col;
   assign rsp_edge_weight  = cot_weight;
   assign rsp_last_of_face = cot_meta.last_face;
   assign rsp_last_of_mesh = cot_meta.last_mesh;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("Busy did not rise after a request was taken.");

   a_mesh_implies_face: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_mesh |-> rsp_last_of_face)
      else $error("Final mesh result is not the last of its face.");

   a_face_triple: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_face |-> $past(rsp_valid, 1) && $past(rsp_valid, 2))
      else $error("A face's results were not on consecutive cycles.");

   a_issue_no_overlap: assert property (@(posedge clock) disable iff (reset)
      issue_ff && (corner_ff != CORNER_CA) |=> issue_ff)
      else $error("Corner issue stopped before the third corner.");

endmodule

### design/mcew_cot.sv
// Pipelined half-cotangent weight unit (weight one in graph mode): one corner enters per cycle.
// Depends on mcew_pkg.
module mcew_cot (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  mcew_pkg::meta_type          in_meta,
   input  mcew_pkg::point_type         in_pi,
   input  mcew_pkg::point_type         in_pm,
   input  mcew_pkg::point_type         in_pj,
   output logic                        out_valid,
   output mcew_pkg::meta_type          out_meta,
   output logic signed [31:0]          out_weight
);
   import mcew_pkg::*;

   localparam int STEPS = Q_W;

   typedef struct packed {
      logic [DSQ_W-1:0]  r;
      logic [TERM_W-1:0] t;
      logic [NSQ_W-1:0]  n;
      logic [Q_W-1:0]    q;
      logic              neg;
      logic              zero;
      meta_type          meta;
   } srch_type;

   logic signed [COORD_W-1:0] pi_c [3];
   logic signed [COORD_W-1:0] pm_c [3];
   logic signed [COORD_W-1:0] pj_c [3];
   logic signed [DIFF_W-1:0]  u_in [3];
   logic signed [DIFF_W-1:0]  v_in [3];
   logic signed [DIFF_W-1:0]  u_ff [3];
   logic signed [DIFF_W-1:0]  v_ff [3];
   logic signed [PROD_W-1:0]  dotp_ff [3];
   logic signed [PROD_W-1:0]  crsa_ff [3];
   logic signed [PROD_W-1:0]  crsb_ff [3];
   logic signed [DOT_W-1:0]   dot_in;
   logic signed [PROD_W:0]    crs_in [3];
   logic [MAG_W-1:0]          mag_in [4];
   logic [MAG_W-1:0]          mag_ff [4];
   logic                      neg3_ff, neg4_ff, neg5_ff;
   logic [2*HALF_W-1:0]       hh_ff [4];
   logic [2*HALF_W-1:0]       hl_ff [4];
   logic [2*HALF_W-1:0]       ll_ff [4];
   logic [SQ_W-1:0]           sq_ff [4];
   logic                      v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   meta_type                  m1_ff, m2_ff, m3_ff, m4_ff, m5_ff;
   srch_type                  srch_ff [STEPS+1];
   logic                      sv_ff [STEPS+1];
   srch_type                  srch_in;
   logic [NSQ_W-1:0]          nsq_in;
   logic [Q_W-1:0]            weight_in;
   logic                      out_valid_ff;
   meta_type                  out_meta_ff;
   logic [Q_W-1:0]            out_weight_ff;

   assign pi_c = '{in_pi.x, in_pi.y, in_pi.z};
   assign pm_c = '{in_pm.x, in_pm.y, in_pm.z};
   assign pj_c = '{in_pj.x, in_pj.y, in_pj.z};

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         u_in[k] = {pi_c[k][COORD_W-1], pi_c[k]} - {pm_c[k][COORD_W-1], pm_c[k]};
         v_in[k] = {pj_c[k][COORD_W-1], pj_c[k]} - {pm_c[k][COORD_W-1], pm_c[k]};
      end
   end

   always_comb begin
      dot_in = {{2{dotp_ff[0][PROD_W-1]}}, dotp_ff[0]}
             + {{2{dotp_ff[1][PROD_W-1]}}, dotp_ff[1]}
             + {{2{dotp_ff[2][PROD_W-1]}}, dotp_ff[2]};
      for (int k = 0; k < 3; k++) begin
         crs_in[k] = {crsa_ff[k][PROD_W-1], crsa_ff[k]} - {crsb_ff[k][PROD_W-1], crsb_ff[k]};
         mag_in[k] = crs_in[k][PROD_W] ? {1'b0, -crs_in[k]} : {1'b0, crs_in[k]};
      end
      mag_in[3] = dot_in[DOT_W-1] ? -dot_in : dot_in;
   end

   assign nsq_in = {2'b0, sq_ff[0]} + {2'b0, sq_ff[1]} + {2'b0, sq_ff[2]};

   always_comb begin
      srch_in.r    = {sq_ff[3], 30'b0};
      srch_in.t    = '0;
      srch_in.n    = nsq_in;
      srch_in.q    = '0;
      srch_in.neg  = neg5_ff;
      srch_in.zero = (nsq_in == '0);
      srch_in.meta = m5_ff;
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         u_ff[k]    <= u_in[k];
         v_ff[k]    <= v_in[k];
         dotp_ff[k] <= u_ff[k] * v_ff[k];
         crsa_ff[k] <= u_ff[(k + 1) % 3] * v_ff[(k + 2) % 3];
         crsb_ff[k] <= u_ff[(k + 2) % 3] * v_ff[(k + 1) % 3];
      end
      for (int k = 0; k < 4; k++) begin
         mag_ff[k] <= mag_in[k];
         hh_ff[k]  <= mag_ff[k][MAG_W-1:HALF_W] * mag_ff[k][MAG_W-1:HALF_W];
         hl_ff[k]  <= mag_ff[k][MAG_W-1:HALF_W] * mag_ff[k][HALF_W-1:0];
         ll_ff[k]  <= mag_ff[k][HALF_W-1:0] * mag_ff[k][HALF_W-1:0];
         sq_ff[k]  <= {hh_ff[k], 68'b0} + {33'b0, hl_ff[k], 35'b0} + {68'b0, ll_ff[k]};
      end
      neg3_ff    <= dot_in[DOT_W-1];
      neg4_ff    <= neg3_ff;
      neg5_ff    <= neg4_ff;
      m1_ff      <= in_meta;
      m2_ff      <= m1_ff;
      m3_ff      <= m2_ff;
      m4_ff      <= m3_ff;
      m5_ff      <= m4_ff;
      srch_ff[0] <= srch_in;
   end

   genvar g;
   generate
      for (g = 0; g < STEPS; g++) begin : g_step
         localparam int B = STEPS - 1 - g;
         logic [CAND_W-1:0] cand;
         logic              fit;
         srch_type          nxt;
         always_comb begin
            cand = (CAND_W'(srch_ff[g].t) << (B + 1)) + (CAND_W'(srch_ff[g].n) << (2 * B));
            fit  = (cand <= CAND_W'(srch_ff[g].r));
            nxt  = srch_ff[g];
            if (fit) begin
               nxt.r = srch_ff[g].r - cand[DSQ_W-1:0];
               nxt.t = srch_ff[g].t + (TERM_W'(srch_ff[g].n) << B);
            end
            nxt.q[B] = fit;
         end
         always_ff @(posedge clock) begin
            srch_ff[g+1] <= nxt;
         end
      end
   endgenerate

   always_comb begin
      if (srch_ff[STEPS].meta.graph) begin
         weight_in = WEIGHT_ONE;
      end else if (srch_ff[STEPS].zero) begin
         weight_in = '0;
      end else if (!srch_ff[STEPS].neg) begin
         weight_in = srch_ff[STEPS].q[Q_W-1] ? POS_SAT : srch_ff[STEPS].q;
      end else begin
         weight_in = (srch_ff[STEPS].q > NEG_SAT) ? NEG_SAT : -srch_ff[STEPS].q;
      end
   end

   always_ff @(posedge clock) begin
      out_meta_ff   <= srch_ff[STEPS].meta;
      out_weight_ff <= weight_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int s = 0; s <= STEPS; s++) begin
            sv_ff[s] <= 1'b0;
         end
      end else begin
         v1_ff        <= in_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         sv_ff[0]     <= v5_ff;
         for (int s = 0; s < STEPS; s++) begin
            sv_ff[s+1] <= sv_ff[s];
         end
         out_valid_ff <= sv_ff[STEPS];
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_meta   = out_meta_ff;
   assign out_weight = out_weight_ff;

endmodule
